### hdl/ibtm_pkg.sv
// Shared constants and types of the IOU box track matcher.
// No dependencies; used by the core and ibtm_iou_unit, not by ibtm_ram.
package ibtm_pkg;

  localparam int MAX_SPOTS_DEF  = 64;
  localparam int COORD_BITS_DEF = 16;

  localparam int            THR_BITS  = 8;
  localparam logic [7:0]    THR_RESET = 8'd128;
  localparam int            CNT_BITS  = 16;
  localparam int            IDX_BITS  = 6;
  localparam int            OUT_TDATA_W = 24;
  localparam int            OUT_TUSER_W = 2;

  typedef struct packed {
    logic valid;
    logic last;
  } tag_t;

  typedef struct packed {
    logic valid;
    logic last;
    logic hit;
  } res_t;

endpackage

### hdl/iou_box_track_matcher_core.sv
// Top level of the IOU box track matcher: sequencer, table, I/O registers.
// Depends on ibtm_pkg, ibtm_ram and ibtm_iou_unit.
//
// Each input transfer is one box; the block compares it in insertion order
// against every stored box and returns one result transfer: the first entry
// whose intersection*256 exceeds iou_threshold*union gets its count bumped
// (saturating at 65535), otherwise the box is appended with count 1, or
// table_full is flagged when all MAX_SPOTS entries are taken. A match ends
// the scan early; while the output register holds an unaccepted result, the
// finished item waits for m_axis_tready. The scan feeds one stored entry
// per cycle from the table RAM through a single multiplier pipeline.
// s_axis_tready is high only while no item is in work; a finished result
// waits in the output register.
module iou_box_track_matcher_core #(
  parameter int MAX_SPOTS  = ibtm_pkg::MAX_SPOTS_DEF,
  parameter int COORD_BITS = ibtm_pkg::COORD_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [ibtm_pkg::THR_BITS-1:0]         cfg_wdata_i,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // x_low, y_low, x_high, y_high, zero pad
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]     s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // entry_index, hit_count, zero pad
  output logic [ibtm_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  // is_new, table_full
  output logic [ibtm_pkg::OUT_TUSER_W-1:0]      m_axis_tuser
);

  localparam int CB     = COORD_BITS;
  localparam int CNT    = ibtm_pkg::CNT_BITS;
  localparam int WORD_W = 6 * CB + CNT;
  localparam int IDX_W  = (MAX_SPOTS > 1) ? $clog2(MAX_SPOTS) : 1;
  localparam int CNT_W  = $clog2(MAX_SPOTS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_AREA = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]                    state_q, state_d;
  logic [ibtm_pkg::THR_BITS-1:0] thr_q;
  logic [4*CB-1:0]               nb_q;
  logic [CNT_W-1:0]              used_q, used_d, issue_q, issue_d;
  logic                          found_q, found_d;
  logic [IDX_W-1:0]              hit_idx_q, hit_idx_d;
  logic [WORD_W-1:0]             hit_word_q, hit_word_d;

  logic                          out_valid_q;
  logic [ibtm_pkg::IDX_BITS-1:0] out_idx_q, out_idx_d;
  logic [CNT-1:0]                out_cnt_q, out_cnt_d;
  logic                          out_new_q, out_new_d, out_full_q, out_full_d;
  logic                          out_load;

  ibtm_pkg::tag_t  tag;
  ibtm_pkg::res_t  res;
  logic [IDX_W-1:0]  res_idx;
  logic [WORD_W-1:0] res_word, rd_word, wdata;
  logic [2*CB-1:0]   area_n;
  logic              we, scan, area_mode;
  logic [IDX_W-1:0]  waddr;
  logic [CNT-1:0]    cnt_old, cnt_next;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign scan          = (state_q == ST_SCAN);
  assign area_mode     = (state_q == ST_AREA);
  assign cnt_old       = hit_word_q[WORD_W-1 -: CNT];
  assign cnt_next      = (cnt_old == '1) ? cnt_old : cnt_old + 1'b1;

  always_comb begin
    state_d    = state_q;
    used_d     = used_q;
    issue_d    = issue_q;
    found_d    = found_q;
    hit_idx_d  = hit_idx_q;
    hit_word_d = hit_word_q;
    tag.valid  = 1'b0;
    tag.last   = 1'b0;
    we         = 1'b0;
    waddr      = hit_idx_q;
    wdata      = {cnt_next, hit_word_q[6*CB-1:0]};
    out_load   = 1'b0;
    out_idx_d  = ibtm_pkg::IDX_BITS'(hit_idx_q);
    out_cnt_d  = cnt_next;
    out_new_d  = 1'b0;
    out_full_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = ST_AREA;
        end
      end
      ST_AREA: begin
        issue_d = '0;
        found_d = 1'b0;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (used_q == '0) begin
          state_d = ST_DONE;
        end else begin
          tag.valid = (issue_q < used_q);
          tag.last  = (issue_q == used_q - 1'b1);
          if (tag.valid) begin
            issue_d = issue_q + 1'b1;
          end
          if (res.valid && res.hit) begin
            found_d    = 1'b1;
            hit_idx_d  = res_idx;
            hit_word_d = res_word;
            state_d    = ST_DONE;
          end else if (res.valid && res.last) begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
          if (found_q) begin
            we = 1'b1;
          end else if (used_q < CNT_W'(MAX_SPOTS)) begin
            we        = 1'b1;
            waddr     = used_q[IDX_W-1:0];
            wdata     = {CNT'(1), area_n, nb_q};
            used_d    = used_q + 1'b1;
            out_idx_d = ibtm_pkg::IDX_BITS'(used_q);
            out_cnt_d = CNT'(1);
            out_new_d = 1'b1;
          end else begin
            out_idx_d  = '0;
            out_cnt_d  = '0;
            out_full_d = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      thr_q       <= ibtm_pkg::THR_RESET;
      used_q      <= '0;
      issue_q     <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      issue_q <= issue_d;
      found_q <= found_d;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      nb_q <= s_axis_tdata[4*CB-1:0];
    end
    hit_idx_q  <= hit_idx_d;
    hit_word_q <= hit_word_d;
    if (out_load) begin
      out_idx_q  <= out_idx_d;
      out_cnt_q  <= out_cnt_d;
      out_new_q  <= out_new_d;
      out_full_q <= out_full_d;
    end
  end

  ibtm_ram #(
    .WIDTH(WORD_W),
    .DEPTH(MAX_SPOTS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(issue_q[IDX_W-1:0]),
    .rdata_o(rd_word)
  );

  ibtm_iou_unit #(
    .COORD_BITS(COORD_BITS),
    .IDX_W     (IDX_W)
  ) u_iou (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .scan_i     (scan),
    .area_mode_i(area_mode),
    .thr_i      (thr_q),
    .nb_i       (nb_q),
    .tag_i      (tag),
    .idx_i      (issue_q[IDX_W-1:0]),
    .rd_word_i  (rd_word),
    .area_n_o   (area_n),
    .res_o      (res),
    .res_idx_o  (res_idx),
    .res_word_o (res_word)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_cnt_q, out_idx_q};
  assign m_axis_tuser  = {out_full_q, out_new_q};

endmodule

### hdl/ibtm_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module ibtm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/ibtm_iou_unit.sv
// Shared IOU test pipeline: overlap, one multiplier, union, threshold compare.
// Depends on ibtm_pkg.
module ibtm_iou_unit #(
  parameter int COORD_BITS = ibtm_pkg::COORD_BITS_DEF,
  parameter int IDX_W      = 6
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        scan_i,
  input  logic                                        area_mode_i,
  input  logic [ibtm_pkg::THR_BITS-1:0]               thr_i,
  input  logic [4*COORD_BITS-1:0]                     nb_i,
  input  ibtm_pkg::tag_t                              tag_i,
  input  logic [IDX_W-1:0]                            idx_i,
  input  logic [6*COORD_BITS+ibtm_pkg::CNT_BITS-1:0]  rd_word_i,
  output logic [2*COORD_BITS-1:0]                     area_n_o,
  output ibtm_pkg::res_t                              res_o,
  output logic [IDX_W-1:0]                            res_idx_o,
  output logic [6*COORD_BITS+ibtm_pkg::CNT_BITS-1:0]  res_word_o
);

  localparam int CB     = COORD_BITS;
  localparam int AW     = 2 * CB;
  localparam int UW     = AW + 1;
  localparam int TB     = ibtm_pkg::THR_BITS;
  localparam int WORD_W = 6 * CB + ibtm_pkg::CNT_BITS;

  ibtm_pkg::tag_t t0_q, t1_q, t2_q, t3_q;
  ibtm_pkg::res_t res_q;
  logic [IDX_W-1:0]  i0_q, i1_q, i2_q, i3_q, i4_q;
  logic [WORD_W-1:0] w1_q, w2_q, w3_q, w4_q;
  logic [CB-1:0]     ix_q, iy_q;
  logic [AW-1:0]     inter_q, inter3_q, area_n_q;
  logic [UW-1:0]     un_q;

  logic signed [CB-1:0] sxl, syl, sxh, syh, nxl, nyl, nxh, nyh;
  logic signed [CB-1:0] x1, y1, x2, y2;
  logic [CB:0]          ix_s, iy_s, dx_s, dy_s, dx_neg, dy_neg;
  logic [CB-1:0]        dxn, dyn, op_a, op_b;
  logic [AW-1:0]        prod;
  logic [UW-1:0]        un_d;
  logic [UW+TB-1:0]     lhs, rhs;
  logic                 hit_d;

  always_comb begin
    sxl = rd_word_i[CB-1:0];
    syl = rd_word_i[2*CB-1:CB];
    sxh = rd_word_i[3*CB-1:2*CB];
    syh = rd_word_i[4*CB-1:3*CB];
    nxl = nb_i[CB-1:0];
    nyl = nb_i[2*CB-1:CB];
    nxh = nb_i[3*CB-1:2*CB];
    nyh = nb_i[4*CB-1:3*CB];
    x1 = (sxl > nxl) ? sxl : nxl;
    y1 = (syl > nyl) ? syl : nyl;
    x2 = (sxh < nxh) ? sxh : nxh;
    y2 = (syh < nyh) ? syh : nyh;
    ix_s = {x2[CB-1], x2} - {x1[CB-1], x1};
    iy_s = {y2[CB-1], y2} - {y1[CB-1], y1};
    dx_s = {nxl[CB-1], nxl} - {nxh[CB-1], nxh};
    dy_s = {nyl[CB-1], nyl} - {nyh[CB-1], nyh};
    dx_neg = -dx_s;
    dy_neg = -dy_s;
    dxn = dx_s[CB] ? dx_neg[CB-1:0] : dx_s[CB-1:0];
    dyn = dy_s[CB] ? dy_neg[CB-1:0] : dy_s[CB-1:0];
    op_a = area_mode_i ? dxn : ix_q;
    op_b = area_mode_i ? dyn : iy_q;
    prod = AW'(op_a * op_b);
    un_d = {1'b0, w2_q[6*CB-1:4*CB]} + {1'b0, area_n_q} - {1'b0, inter_q};
    lhs = {1'b0, inter3_q, {TB{1'b0}}};
    rhs = (UW+TB)'(thr_i * un_q);
    hit_d = lhs > rhs;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t0_q  <= '0;
      t1_q  <= '0;
      t2_q  <= '0;
      t3_q  <= '0;
      res_q <= '0;
    end else begin
      t0_q.valid  <= tag_i.valid && scan_i;
      t0_q.last   <= tag_i.last;
      t1_q.valid  <= t0_q.valid && scan_i;
      t1_q.last   <= t0_q.last;
      t2_q.valid  <= t1_q.valid && scan_i;
      t2_q.last   <= t1_q.last;
      t3_q.valid  <= t2_q.valid && scan_i;
      t3_q.last   <= t2_q.last;
      res_q.valid <= t3_q.valid && scan_i;
      res_q.last  <= t3_q.last;
      res_q.hit   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i0_q <= idx_i;
    i1_q <= i0_q;
    w1_q <= rd_word_i;
    ix_q <= (ix_s[CB] || iy_s[CB]) ? '0 : ix_s[CB-1:0];
    iy_q <= (ix_s[CB] || iy_s[CB]) ? '0 : iy_s[CB-1:0];
    i2_q <= i1_q;
    w2_q <= w1_q;
    inter_q <= prod;
    if (area_mode_i) begin
      area_n_q <= prod;
    end
    i3_q <= i2_q;
    w3_q <= w2_q;
    inter3_q <= inter_q;
    un_q <= un_d;
    i4_q <= i3_q;
    w4_q <= w3_q;
  end

  assign area_n_o   = area_n_q;
  assign res_o      = res_q;
  assign res_idx_o  = i4_q;
  assign res_word_o = w4_q;

endmodule
